// ===== sv/vclc_pkg.sv =====
// Shared types and constants for the voxel chunk LRU cache.
package vclc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned VIDX_W  = 12;
  localparam int unsigned EPOS_W  = 12;

  typedef struct packed {
    logic signed [COORD_W-1:0] voxel_x;
    logic signed [COORD_W-1:0] voxel_y;
    logic signed [COORD_W-1:0] voxel_z;
  } in_word_t;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_W-1:0]        slot;
    logic [VIDX_W-1:0]        voxel_index;
    logic                     evict_valid;
    logic signed [EPOS_W-1:0] evict_chunk_x;
    logic signed [EPOS_W-1:0] evict_chunk_y;
    logic signed [EPOS_W-1:0] evict_chunk_z;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic commit;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

endpackage

// ===== sv/vclc_ctrl.sv =====
// Control state machine: input capture, lookup commit and output valid.
module vclc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vclc_pkg::cmd_t cmd_o
);
  import vclc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.load_in = 1'b0;
    cmd_o.commit  = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/vclc_dpath.sv =====
// Datapath: coordinate split, tag table, LRU ages and output register.
module vclc_dpath #(
  parameter int unsigned CHUNK_EDGE   = 16,
  parameter int unsigned ACTIVE_SLOTS = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vclc_pkg::cmd_t     cmd_i,
  input  vclc_pkg::in_word_t in_word_i,
  output vclc_pkg::out_word_t out_word_o
);
  import vclc_pkg::*;

  localparam int unsigned SHIFT  = $clog2(CHUNK_EDGE);
  localparam int unsigned CPOS_W = COORD_BITS - SHIFT;
  localparam int unsigned POS_W  = 3 * CPOS_W;
  localparam int unsigned SW     = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(ACTIVE_SLOTS + 1);
  localparam int unsigned EXT_W  = (CPOS_W > EPOS_W) ? CPOS_W : EPOS_W;
  localparam int unsigned CAT_W  = 3 * SHIFT;

  logic [COORD_BITS-1:0] cx_q, cy_q, cz_q;
  logic [POS_W-1:0]      pos_q [ACTIVE_SLOTS];
  logic [SW-1:0]         age_q [ACTIVE_SLOTS];
  logic [CNT_W-1:0]      fill_q;
  out_word_t             out_q;

  logic [POS_W-1:0]        key;
  logic [ACTIVE_SLOTS-1:0] occ, match, oldest;
  logic                    hit, full;
  logic [SW-1:0]           hit_idx, victim_idx, slot_idx, old_age;
  logic [POS_W-1:0]        victim_pos;
  logic signed [CPOS_W-1:0] vx, vy, vz;
  logic signed [EXT_W-1:0]  ex, ey, ez;
  logic [CAT_W-1:0]         cat;
  out_word_t               res;

  always_comb begin
    key = {cx_q[COORD_BITS-1:SHIFT], cy_q[COORD_BITS-1:SHIFT], cz_q[COORD_BITS-1:SHIFT]};
    hit_idx    = '0;
    victim_idx = '0;
    for (int i = 0; i < ACTIVE_SLOTS; i++) begin
      occ[i]    = CNT_W'(i) < fill_q;
      match[i]  = occ[i] && (pos_q[i] == key);
      oldest[i] = age_q[i] == SW'(ACTIVE_SLOTS - 1);
    end
    for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SW'(i);
      end
      if (oldest[i]) begin
        victim_idx = SW'(i);
      end
    end
    hit  = |match;
    full = fill_q == CNT_W'(ACTIVE_SLOTS);
    priority if (hit) begin
      slot_idx = hit_idx;
      old_age  = age_q[hit_idx];
    end else if (!full) begin
      slot_idx = SW'(fill_q);
      old_age  = SW'(fill_q);
    end else begin
      slot_idx = victim_idx;
      old_age  = SW'(ACTIVE_SLOTS - 1);
    end
    victim_pos = pos_q[victim_idx];
    vx = victim_pos[3*CPOS_W-1:2*CPOS_W];
    vy = victim_pos[2*CPOS_W-1:CPOS_W];
    vz = victim_pos[CPOS_W-1:0];
    ex = EXT_W'(vx);
    ey = EXT_W'(vy);
    ez = EXT_W'(vz);
    cat = {cx_q[SHIFT-1:0], cy_q[SHIFT-1:0], cz_q[SHIFT-1:0]};
    res.hit           = hit;
    res.slot          = SLOT_W'(slot_idx);
    res.voxel_index   = VIDX_W'(cat);
    res.evict_valid   = !hit && full;
    res.evict_chunk_x = res.evict_valid ? ex[EPOS_W-1:0] : '0;
    res.evict_chunk_y = res.evict_valid ? ey[EPOS_W-1:0] : '0;
    res.evict_chunk_z = res.evict_valid ? ez[EPOS_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.commit && !hit && !full) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cx_q <= COORD_BITS'($unsigned(in_word_i.voxel_x));
      cy_q <= COORD_BITS'($unsigned(in_word_i.voxel_y));
      cz_q <= COORD_BITS'($unsigned(in_word_i.voxel_z));
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
        if (SW'(i) == slot_idx) begin
          age_q[i] <= '0;
        end else if (occ[i] && (age_q[i] < old_age)) begin
          age_q[i] <= age_q[i] + 1'b1;
        end
      end
      if (!hit) begin
        pos_q[slot_idx] <= key;
      end
      out_q <= res;
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== sv/voxel_chunk_lru_cache.sv =====
// Voxel chunk LRU cache top level: controller and datapath.
// Each word is captured, then looked up, aged and written to the output register;
// no new word is taken until that lookup commits.
// The lookup cycle waits while the output register holds an untaken result.
// Reset: asynchronous, active low; clears state, output valid and fill count.
// Tag and age entries are not reset; only filled slots are ever looked at.
module voxel_chunk_lru_cache #(
  parameter int unsigned CHUNK_EDGE   = 16,
  parameter int unsigned ACTIVE_SLOTS = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vclc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vclc_pkg::out_word_t out_word_o
);
  import vclc_pkg::*;

  cmd_t cmd;

  vclc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  vclc_dpath #(
    .CHUNK_EDGE   (CHUNK_EDGE),
    .ACTIVE_SLOTS (ACTIVE_SLOTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== sv/vclc_checker.sv =====
// Port-level assertions for the voxel chunk LRU cache, bound to the top level.
module vclc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input vclc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input vclc_pkg::out_word_t out_word_o
);
  import vclc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again during lookup");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.evict_valid |-> !out_word_o.hit)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.evict_valid |->
      out_word_o.evict_chunk_x == '0 && out_word_o.evict_chunk_y == '0 &&
      out_word_o.evict_chunk_z == '0)
    else $error("evicted position not cleared without eviction");

endmodule

bind voxel_chunk_lru_cache vclc_checker u_vclc_checker (.*);

// ===== test/tb_voxel_chunk_lru_cache.sv =====
// Self-checking testbench for the voxel chunk LRU cache: directed table, then random words.
module tb_voxel_chunk_lru_cache;
  import vclc_pkg::*;

  localparam int NUM_SLOTS   = 1 << SLOT_W;
  localparam int OFS_W       = 4;
  localparam int NUM_DIR     = 20;
  localparam int RAND_PHASE  = 262;
  localparam int HOT_CHUNKS  = 12;
  localparam int MAX_GAP     = 40;
  localparam int MAX_STALL   = 30;
  localparam int STUCK_LIMIT = 1000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [EPOS_W-1:0] x;
    logic signed [EPOS_W-1:0] y;
    logic signed [EPOS_W-1:0] z;
  } chunk_pos_t;

  typedef struct packed {
    logic      typed;
    in_word_t  word;
    out_word_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIR] = '{
    '{1'b1, '{16'sd0, 16'sd0, 16'sd0},
      '{1'b0, 3'd0, 12'h000, 1'b0, 12'sd0, 12'sd0, 12'sd0}},
    '{1'b1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{1'b0, 3'd1, 12'hFFF, 1'b0, 12'sd0, 12'sd0, 12'sd0}},
    '{1'b1, '{16'sh8000, 16'sh8000, 16'sh8000},
      '{1'b0, 3'd2, 12'h000, 1'b0, 12'sd0, 12'sd0, 12'sd0}},
    '{1'b1, '{-16'sd1, -16'sd1, -16'sd1},
      '{1'b0, 3'd3, 12'hFFF, 1'b0, 12'sd0, 12'sd0, 12'sd0}},
    '{1'b1, '{16'sd15, 16'sd0, 16'sd0},
      '{1'b1, 3'd0, 12'hF00, 1'b0, 12'sd0, 12'sd0, 12'sd0}},
    '{1'b0, '{16'sd16, -16'sd16, 16'sd5}, '0},
    '{1'b0, '{16'sd100, 16'sd200, 16'sd300}, '0},
    '{1'b0, '{-16'sd500, 16'sd600, -16'sd700}, '0},
    '{1'b0, '{16'sd4096, -16'sd4097, 16'sd12345}, '0},
    '{1'b0, '{16'sd0, 16'sd1, 16'sd2}, '0},
    '{1'b0, '{16'sh7FF0, 16'sh8000, 16'sd0}, '0},
    '{1'b0, '{16'sd20000, -16'sd20000, 16'sd1}, '0},
    '{1'b0, '{-16'sd1, -16'sd1, -16'sd1}, '0},
    '{1'b0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '0},
    '{1'b0, '{16'sh8000, 16'sh8000, 16'sh8000}, '0},
    '{1'b0, '{16'sd3, -16'sd3, 16'sd17}, '0},
    '{1'b0, '{16'sd0, 16'sd0, 16'sd0}, '0},
    '{1'b0, '{16'sd16, -16'sd16, 16'sd5}, '0},
    '{1'b0, '{16'sh8000, 16'sh7FFF, -16'sd1}, '0},
    '{1'b0, '{16'sd8000, -16'sd8000, 16'sd800}, '0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  chunk_pos_t  cached_pos [NUM_SLOTS];
  int unsigned lru_age [NUM_SLOTS];
  int          filled_slots = 0;
  chunk_pos_t  hot_chunks [HOT_CHUNKS];
  out_word_t   due_results [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int stall_run     = 0;
  int stuck_cycles  = 0;
  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int hits_seen     = 0;
  int evicts_seen   = 0;

  voxel_chunk_lru_cache uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_word_t lookup_chunk(in_word_t w);
    chunk_pos_t  p;
    out_word_t   r;
    int          slot;
    int          match;
    int unsigned old_age;
    p.x   = w.voxel_x[COORD_W-1:OFS_W];
    p.y   = w.voxel_y[COORD_W-1:OFS_W];
    p.z   = w.voxel_z[COORD_W-1:OFS_W];
    r     = '0;
    match = -1;
    for (int i = 0; i < filled_slots; i++) begin
      if (match < 0 && cached_pos[i] == p) match = i;
    end
    if (match >= 0) begin
      slot    = match;
      old_age = lru_age[slot];
      r.hit   = 1'b1;
    end else if (filled_slots < NUM_SLOTS) begin
      slot             = filled_slots;
      old_age          = filled_slots;
      cached_pos[slot] = p;
      lru_age[slot]    = filled_slots;
      filled_slots++;
    end else begin
      slot = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (lru_age[i] > lru_age[slot]) slot = i;
      end
      r.evict_valid    = 1'b1;
      r.evict_chunk_x  = cached_pos[slot].x;
      r.evict_chunk_y  = cached_pos[slot].y;
      r.evict_chunk_z  = cached_pos[slot].z;
      old_age          = lru_age[slot];
      cached_pos[slot] = p;
    end
    for (int i = 0; i < filled_slots; i++) begin
      if (lru_age[i] < old_age) lru_age[i]++;
    end
    lru_age[slot] = 0;
    r.slot        = slot[SLOT_W-1:0];
    r.voxel_index = {w.voxel_x[OFS_W-1:0], w.voxel_y[OFS_W-1:0], w.voxel_z[OFS_W-1:0]};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %0d (%s): got 0x%0h, expected 0x%0h", errors, what, got, want);
  endtask

  task automatic check_result(out_word_t got, out_word_t want);
    if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
    if (got.voxel_index !== want.voxel_index)
      report_mismatch("voxel_index", got.voxel_index, want.voxel_index);
    if (got.evict_valid !== want.evict_valid)
      report_mismatch("evict_valid", got.evict_valid, want.evict_valid);
    if (got.evict_chunk_x !== want.evict_chunk_x)
      report_mismatch("evict_chunk_x", got.evict_chunk_x, want.evict_chunk_x);
    if (got.evict_chunk_y !== want.evict_chunk_y)
      report_mismatch("evict_chunk_y", got.evict_chunk_y, want.evict_chunk_y);
    if (got.evict_chunk_z !== want.evict_chunk_z)
      report_mismatch("evict_chunk_z", got.evict_chunk_z, want.evict_chunk_z);
  endtask

  // call at a rising edge; returns at the edge that takes the word
  task automatic send_voxel(in_word_t w, logic typed, out_word_t want);
    int        gap;
    logic      taken;
    out_word_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predicted = lookup_chunk(w);
    if (typed) predicted = want;
    due_results = {due_results, predicted};
    words_sent++;
  endtask

  function automatic chunk_pos_t random_chunk();
    chunk_pos_t c;
    c.x = EPOS_W'($urandom);
    c.y = EPOS_W'($urandom);
    c.z = EPOS_W'($urandom);
    return c;
  endfunction

  function automatic in_word_t random_voxel();
    in_word_t w;
    int       pick;
    int       k;
    pick = $urandom_range(99);
    k    = $urandom_range(HOT_CHUNKS - 1);
    if (pick < 10) begin
      w = in_word_t'({$urandom, $urandom});
    end else begin
      // refresh one hot chunk now and then so evicted chunks keep turning over
      if (pick < 20) hot_chunks[k] = random_chunk();
      w.voxel_x = {hot_chunks[k].x, OFS_W'($urandom_range(15))};
      w.voxel_y = {hot_chunks[k].y, OFS_W'($urandom_range(15))};
      w.voxel_z = {hot_chunks[k].z, OFS_W'($urandom_range(15))};
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (stall_run >= MAX_STALL || $urandom_range(99) >= stall_pct) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else begin
      out_stall_i <= 1'b1;
      stall_run++;
    end
  end

  // sample between edges so handshakes are read settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", out_word_o, '0);
        end else begin
          check_result(out_word_o, due_results.pop_front());
          results_seen++;
          if (out_word_o.hit) hits_seen++;
          if (out_word_o.evict_valid) evicts_seen++;
        end
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no word moved in %0d cycles", STUCK_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < HOT_CHUNKS; i++) hot_chunks[i] = random_chunk();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_DIR; i++)
      send_voxel(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int i = 0; i < RAND_PHASE; i++) send_voxel(random_voxel(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
    if (due_results.size() != 0) report_mismatch("results never arrived", due_results.size(), 0);
    $display("sent %0d voxel words (%0d directed) across four idle and stall mixes",
             words_sent, NUM_DIR);
    $display("checked %0d results: %0d hits, %0d evictions", results_seen, hits_seen,
             evicts_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
